[sv/cacf_pkg.sv]
`timescale 1ns / 1ps
// cacf_pkg: constants, register indexes and shared types of the ca-cfar detector
// no dependencies; used by cell_averaging_cfar and cacf_cell

package cacf_pkg;

    localparam int DEF_MAX_HALF_WINDOW = 64;
    localparam int DEF_SAMPLE_BITS     = 16;

    localparam int WIN_SPAN_W   = 7;
    localparam int GUARD_SPAN_W = 5;
    localparam int SCALE_W      = 24;
    localparam int SCALE_FRAC   = 16;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 2;

    localparam int INDEX_W = 16;
    localparam int THR_W   = 23;
    localparam int POWER_CAP_W = 64;

    localparam logic [INDEX_W-1:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [THR_W-1:0]   THRESH_MAX = 23'h7FFFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_WIN_SPAN        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GUARD_SPAN      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_SCALE = 2'd2;

    localparam logic [WIN_SPAN_W-1:0]   WIN_SPAN_RST   = 7'd8;
    localparam logic [GUARD_SPAN_W-1:0] GUARD_SPAN_RST = 5'd1;
    localparam logic [SCALE_W-1:0]      SCALE_RST      = 24'd65536;

    typedef struct packed {
        logic shift_in;
        logic rotate;
    } cell_ctrl_t;

endpackage

[sv/cell_averaging_cfar.sv]
`timescale 1ns / 1ps
// cell_averaging_cfar: top level of the cell-averaging cfar detector
// uses cacf_pkg, cacf_cell (delay line) and cacf_isqrt (threshold root)
//
// Each item shifts into a line of 2*MAX_HALF_WINDOW+1 sample cells. An item
// that does not complete a full window in its frame produces no result, and
// the input stays ready. An item that does produces one result and holds off
// the input until that result is loaded into the output register, which also
// waits while the previous result is still not taken: the line rotates once
// through its single squarer to build the reference sum and the cell-under-test
// square, two registered partial products form the scaled power, and the square
// root retires two power bits per cycle, the noise power being 46 bits wide at
// the defaults. A finished result waits in the output register while the next
// item is taken. Configuration is written through cfg_write/cfg_index/cfg_data;
// index 3 is ignored.

module cell_averaging_cfar #(
    parameter int MAX_HALF_WINDOW = cacf_pkg::DEF_MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = cacf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cacf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cacf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                first,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cacf_pkg::INDEX_W-1:0]        cell_index,
    output logic [cacf_pkg::THR_W-1:0]          threshold,
    output logic                                detect
);

    localparam int LINE_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int HW_W       = $clog2(MAX_HALF_WINDOW + 1);
    localparam int BND_W      = $clog2(2 * MAX_HALF_WINDOW + (2 ** cacf_pkg::GUARD_SPAN_W) + 2);
    localparam int FC_W       = cacf_pkg::INDEX_W + 1;
    localparam int SQ_W       = 2 * SAMPLE_BITS;
    localparam int SUM_W      = SQ_W - 1 + $clog2(2 * MAX_HALF_WINDOW);
    localparam int LO_W       = (SUM_W + 1) / 2;
    localparam int HI_W       = SUM_W - LO_W;
    localparam int PROD_W     = SUM_W + cacf_pkg::SCALE_W;
    localparam int PFULL_W    = PROD_W - cacf_pkg::SCALE_FRAC;
    localparam int PWR_W      = (PFULL_W > cacf_pkg::POWER_CAP_W) ? cacf_pkg::POWER_CAP_W
                                                                  : PFULL_W;
    localparam int ROOT_W     = (PWR_W + 1) / 2;
    localparam int CMP_W      = (SQ_W > PWR_W) ? SQ_W : PWR_W;
    localparam int TCMP_W     = (ROOT_W > cacf_pkg::THR_W) ? ROOT_W : cacf_pkg::THR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DRAIN,
        ST_MUL,
        ST_POWER,
        ST_ROOT,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [cacf_pkg::WIN_SPAN_W-1:0]    win_span_reg;
    logic [cacf_pkg::GUARD_SPAN_W-1:0]  guard_span_reg;
    logic [cacf_pkg::SCALE_W-1:0]       scale_reg;
    logic [cacf_pkg::INDEX_W-1:0]       frame_count_reg;
    logic [IDX_W-1:0]                   rot_cnt_reg;
    logic                               sq_vld_reg;
    logic                               out_valid_reg;
    logic [cacf_pkg::INDEX_W-1:0]       cell_idx_reg;
    logic [cacf_pkg::INDEX_W-1:0]       cell_index_reg;
    logic [cacf_pkg::THR_W-1:0]         threshold_reg;
    logic                               detect_reg;

    logic [SQ_W-1:0]                    sq_reg;
    logic                               is_ref_reg;
    logic                               is_cut_reg;
    logic [SUM_W-1:0]                   sum_reg;
    logic [SQ_W-1:0]                    cut_sq_reg;
    logic [LO_W+cacf_pkg::SCALE_W-1:0]  p_lo_reg;
    logic [HI_W+cacf_pkg::SCALE_W-1:0]  p_hi_reg;
    logic [PWR_W-1:0]                   power_reg;

    cacf_pkg::cell_ctrl_t               cell_ctrl;
    logic signed [SAMPLE_BITS-1:0]      line [LINE_DEPTH];

    logic                               accept;
    logic [HW_W-1:0]                    hw_eff;
    logic                               no_ref;
    logic [cacf_pkg::INDEX_W-1:0]       fc_next;
    logic                               emit;
    logic [cacf_pkg::INDEX_W-1:0]       cell_cmb;
    logic [BND_W-1:0]                   rc_b;
    logic [BND_W-1:0]                   hw_b;
    logic [BND_W-1:0]                   hg_b;
    logic                               is_ref_cmb;
    logic                               is_cut_cmb;
    logic signed [SQ_W-1:0]             sq_signed;
    logic [PROD_W-1:0]                  prod;
    logic [PFULL_W-1:0]                 power_full;
    logic [PWR_W-1:0]                   power_cmb;
    logic                               root_start;
    logic                               root_done;
    logic [ROOT_W-1:0]                  root;
    logic                               out_load;
    logic [cacf_pkg::THR_W-1:0]         thr_cmb;
    logic                               detect_cmb;

    // delay line
    assign cell_ctrl.shift_in = accept;
    assign cell_ctrl.rotate   = (state_reg == ST_ROTATE);

    for (genvar k = 0; k < LINE_DEPTH; k++)
    begin : g_line
        cacf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .from_prev ((k == 0) ? sample : line[(k == 0) ? 0 : k - 1]),
            .from_next (line[(k == LINE_DEPTH - 1) ? 0 : k + 1]),
            .data      (line[k])
        );
    end

    // window geometry
    assign accept = in_valid && in_ready;
    assign hw_eff = (int'(win_span_reg) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                          : HW_W'(win_span_reg);
    assign no_ref = int'(guard_span_reg) >= int'(hw_eff);

    always_comb
    begin
        if (first)
        begin
            fc_next = cacf_pkg::INDEX_W'(1);
        end
        else if (frame_count_reg == cacf_pkg::COUNT_MAX)
        begin
            fc_next = frame_count_reg;
        end
        else
        begin
            fc_next = frame_count_reg + cacf_pkg::INDEX_W'(1);
        end
    end

    assign emit = FC_W'(fc_next) >= ((FC_W'(hw_eff) << 1) + FC_W'(1));
    assign cell_cmb = (fc_next == cacf_pkg::COUNT_MAX) ? cacf_pkg::COUNT_MAX
                    : fc_next - cacf_pkg::INDEX_W'(1) - cacf_pkg::INDEX_W'(hw_eff);

    assign rc_b = BND_W'(rot_cnt_reg);
    assign hw_b = BND_W'(hw_eff);
    assign hg_b = BND_W'(guard_span_reg);
    assign is_ref_cmb = !no_ref && ((rc_b + hg_b < hw_b)
                                 || ((rc_b > hw_b + hg_b) && (rc_b <= (hw_b << 1))));
    assign is_cut_cmb = (rc_b == hw_b);

    assign sq_signed = line[0] * line[0];

    // scaled noise power
    assign prod       = (PROD_W'(p_hi_reg) << LO_W) + PROD_W'(p_lo_reg);
    assign power_full = prod[PROD_W-1:cacf_pkg::SCALE_FRAC];
    assign power_cmb  = ((power_full >> cacf_pkg::POWER_CAP_W) != '0) ? '1
                                                                      : PWR_W'(power_full);

    assign root_start = (state_reg == ST_POWER);

    cacf_isqrt #(
        .VALUE_W (PWR_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (power_cmb),
        .done  (root_done),
        .root  (root)
    );

    // result
    always_comb
    begin
        if (no_ref)
        begin
            thr_cmb = '0;
        end
        else if (TCMP_W'(root) > TCMP_W'(cacf_pkg::THRESH_MAX))
        begin
            thr_cmb = cacf_pkg::THRESH_MAX;
        end
        else
        begin
            thr_cmb = cacf_pkg::THR_W'(root);
        end
    end

    assign detect_cmb = !no_ref && (CMP_W'(cut_sq_reg) > CMP_W'(power_reg));
    assign out_load   = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            win_span_reg    <= cacf_pkg::WIN_SPAN_RST;
            guard_span_reg  <= cacf_pkg::GUARD_SPAN_RST;
            scale_reg       <= cacf_pkg::SCALE_RST;
            frame_count_reg <= '0;
            rot_cnt_reg     <= '0;
            sq_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            cell_idx_reg    <= '0;
            cell_index_reg  <= '0;
            threshold_reg   <= '0;
            detect_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    cacf_pkg::REG_WIN_SPAN:
                    begin
                        win_span_reg <= cfg_data[cacf_pkg::WIN_SPAN_W-1:0];
                    end
                    cacf_pkg::REG_GUARD_SPAN:
                    begin
                        guard_span_reg <= cfg_data[cacf_pkg::GUARD_SPAN_W-1:0];
                    end
                    cacf_pkg::REG_THRESHOLD_SCALE:
                    begin
                        scale_reg <= cfg_data[cacf_pkg::SCALE_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            sq_vld_reg <= (state_reg == ST_ROTATE);

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                cell_index_reg <= cell_idx_reg;
                threshold_reg  <= thr_cmb;
                detect_reg     <= detect_cmb;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        frame_count_reg <= fc_next;
                        if (emit)
                        begin
                            cell_idx_reg <= cell_cmb;
                            rot_cnt_reg  <= '0;
                            state_reg    <= ST_ROTATE;
                        end
                    end
                end
                ST_ROTATE:
                begin
                    rot_cnt_reg <= rot_cnt_reg + IDX_W'(1);
                    if (rot_cnt_reg == IDX_W'(LINE_DEPTH - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_POWER;
                end
                ST_POWER:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROTATE)
        begin
            sq_reg     <= $unsigned(sq_signed);
            is_ref_reg <= is_ref_cmb;
            is_cut_reg <= is_cut_cmb;
        end

        if (accept)
        begin
            sum_reg <= '0;
        end
        else if (sq_vld_reg && is_ref_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(sq_reg);
        end

        if (sq_vld_reg && is_cut_reg)
        begin
            cut_sq_reg <= sq_reg;
        end

        if (state_reg == ST_MUL)
        begin
            p_lo_reg <= (LO_W + cacf_pkg::SCALE_W)'(sum_reg[LO_W-1:0])
                      * (LO_W + cacf_pkg::SCALE_W)'(scale_reg);
            p_hi_reg <= (HI_W + cacf_pkg::SCALE_W)'(sum_reg[SUM_W-1:LO_W])
                      * (HI_W + cacf_pkg::SCALE_W)'(scale_reg);
        end

        if (state_reg == ST_POWER)
        begin
            power_reg <= power_cmb;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_index = cell_index_reg;
    assign threshold  = threshold_reg;
    assign detect     = detect_reg;

endmodule

[sv/cacf_cell.sv]
`timescale 1ns / 1ps
// cacf_cell: one sample cell of the delay line
// shifts toward older cells on a new item, rotates toward cell 0 while scanning; uses cacf_pkg

module cacf_cell #(
    parameter int SAMPLE_BITS = cacf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  cacf_pkg::cell_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] from_prev,
    input  logic signed [SAMPLE_BITS-1:0] from_next,
    output logic signed [SAMPLE_BITS-1:0] data
);

    logic signed [SAMPLE_BITS-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        priority if (ctrl.shift_in)
        begin
            val_reg <= from_prev;
        end
        else if (ctrl.rotate)
        begin
            val_reg <= from_next;
        end
        else
        begin
            val_reg <= val_reg;
        end
    end

    assign data = val_reg;

endmodule

[sv/cacf_isqrt.sv]
`timescale 1ns / 1ps
// cacf_isqrt: iterative integer square root, two bits of the operand per cycle
// done pulses for one cycle after the last step; uses no package

module cacf_isqrt #(
    parameter int VALUE_W = 46
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_W-1:0]       value,
    output logic                     done,
    output logic [(VALUE_W+1)/2-1:0] root
);

    localparam int NIT   = (VALUE_W + 1) / 2;
    localparam int PAD_W = 2 * NIT;
    localparam int REM_W = NIT + 2;
    localparam int CNT_W = (NIT > 1) ? $clog2(NIT) : 1;

    logic [PAD_W-1:0] val_reg;
    logic [REM_W-1:0] rem_reg;
    logic [NIT-1:0]   root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             take;

    assign shifted = {rem_reg[NIT-1:0], val_reg[PAD_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NIT - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= PAD_W'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= val_reg << 2;
            if (take)
            begin
                rem_reg  <= shifted - trial;
                root_reg <= {root_reg[NIT-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                root_reg <= {root_reg[NIT-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[tb/cfar_sb_pkg.sv]
`timescale 1ns / 1ps
// cfar_sb_pkg: scoreboard for the ca-cfar detector testbench, predicts each result
// from the accepted samples and the register settings and checks the block's output
// depends on cacf_pkg for widths, reset values and register indexes

package cfar_sb_pkg;

    import cacf_pkg::*;

    localparam int LINE_LEN = 2 * DEF_MAX_HALF_WINDOW + 1;

    typedef logic signed [DEF_SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic [THR_W-1:0]   thr;
        logic               hit;
    } cfar_cell_t;

    class cfar_scoreboard;

        logic [WIN_SPAN_W-1:0]    win_span    = WIN_SPAN_RST;
        logic [GUARD_SPAN_W-1:0]  guard_span  = GUARD_SPAN_RST;
        logic [SCALE_W-1:0]       scale       = SCALE_RST;
        sample_t                  taps [LINE_LEN] = '{default: '0};
        logic [INDEX_W-1:0]       frame_count = '0;
        cfar_cell_t               expected_cells [$];
        int                       errors = 0;

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_WIN_SPAN:        win_span   = data[WIN_SPAN_W-1:0];
                REG_GUARD_SPAN:      guard_span = data[GUARD_SPAN_W-1:0];
                REG_THRESHOLD_SCALE: scale      = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            int b;
            root = 0;
            for (b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        function void note_sample(sample_t s, logic f);
            int unsigned     hw;
            int unsigned     hg;
            int              k;
            longint unsigned ref_sum;
            longint unsigned power;
            longint unsigned root;
            longint unsigned cut_sq;
            logic [95:0]     prod;
            cfar_cell_t      want;

            hw = (win_span > DEF_MAX_HALF_WINDOW) ? DEF_MAX_HALF_WINDOW : win_span;
            hg = guard_span;

            for (k = LINE_LEN - 1; k > 0; k--)
                taps[k] = taps[k-1];
            taps[0] = s;

            if (f)
                frame_count = INDEX_W'(1);
            else if (frame_count != COUNT_MAX)
                frame_count++;

            if (frame_count < 2 * hw + 1)
                return;

            want.idx = (frame_count == COUNT_MAX) ? COUNT_MAX : INDEX_W'(frame_count - 1 - hw);

            if (hg < hw)
            begin
                ref_sum = 0;
                for (k = 0; k < int'(hw - hg); k++)
                    ref_sum += longint'(taps[k]) * longint'(taps[k]);
                for (k = hw + hg + 1; k <= int'(2 * hw); k++)
                    ref_sum += longint'(taps[k]) * longint'(taps[k]);
                prod = 96'(ref_sum) * 96'(scale);
                prod = prod >> SCALE_FRAC;
                power = (prod[95:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
                root = int_sqrt(power);
                want.thr = (root > THRESH_MAX) ? THRESH_MAX : THR_W'(root);
                cut_sq = longint'(taps[hw]) * longint'(taps[hw]);
                want.hit = (cut_sq > power);
            end
            else
            begin
                want.thr = '0;
                want.hit = 1'b0;
            end

            expected_cells.push_back(want);
        endfunction

        function void check_cell(logic [INDEX_W-1:0] idx, logic [THR_W-1:0] thr, logic hit);
            cfar_cell_t want;
            if (expected_cells.size() == 0)
            begin
                $error("result with none expected: cell_index %0d threshold %0d detect %0d",
                       idx, thr, hit);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            if (idx !== want.idx)
            begin
                $error("cell_index mismatch: expected %0d, actual %0d", want.idx, idx);
                errors++;
            end
            if (thr !== want.thr)
            begin
                $error("threshold mismatch: expected %0d, actual %0d", want.thr, thr);
                errors++;
            end
            if (hit !== want.hit)
            begin
                $error("detect mismatch: expected %0d, actual %0d", want.hit, hit);
                errors++;
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: testbench of cell_averaging_cfar, directed frames then random frames
// under random register settings and random idling on both handshakes
// depends on cacf_pkg, cfar_sb_pkg and the cell_averaging_cfar rtl

module tb_top;

    import cacf_pkg::*;
    import cfar_sb_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     MAX_HW       = DEF_MAX_HALF_WINDOW;
    localparam int     DRAIN_CYCLES = 2 * MAX_HW + 100;
    localparam int     RANDOM_ITEMS = 400;
    localparam int     QUIET_ITEMS  = 320;
    localparam longint LIMIT_NS     = 30_000_000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_write  = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    sample_t                sample     = '0;
    logic                   first      = 1'b0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [INDEX_W-1:0]     cell_index;
    logic [THR_W-1:0]       threshold;
    logic                   detect;

    logic quiet = 1'b0;
    int   out_hold = 0;
    int   random_items = 0;

    cfar_scoreboard sb = new;

    cell_averaging_cfar i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .first      (first),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_index (cell_index),
        .threshold  (threshold),
        .detect     (detect)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_cell(cell_index, threshold, detect);
            if (in_valid && in_ready)
                sb.note_sample(sample, first);
        end
    end

    always @(posedge clk)
    begin
        if (!quiet && out_hold == 0 && $urandom_range(0, 7) == 0)
        begin
            out_hold  <= $urandom_range(1, 6);
            out_ready <= 1'b0;
        end
        else if (out_hold > 1)
        begin
            out_hold  <= out_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_hold  <= 0;
            out_ready <= 1'b1;
        end
    end

    task automatic send_sample(input sample_t s, input logic f);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        first    <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        sb.set_reg(index, data);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid  <= 1'b0;
        cfg_write <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 2))
                    0:       return sample_t'(16'h8000);
                    1:       return sample_t'(16'h7FFF);
                    default: return '0;
                endcase
            end
            1, 2:    return sample_t'($urandom);
            3:       return sample_t'(($urandom_range(0, 1) ? 1 : -1)
                                      * int'($urandom_range(16384, 32767)));
            default: return sample_t'(int'($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    task automatic run_random_phase(input int phase_no);
        int                    hw_data;
        int                    hw_eff;
        int                    hg;
        int                    n;
        int                    i;
        logic                  f;
        logic [CFG_DATA_W-1:0] scale_v;

        if (phase_no == 1)
            hw_data = 127;
        else
        begin
            case ($urandom_range(0, 9))
                0:       hw_data = 2;
                1:       hw_data = MAX_HW;
                2:       hw_data = $urandom_range(MAX_HW + 1, 127);
                default: hw_data = $urandom_range(2, 16);
            endcase
        end
        hw_eff = (hw_data > MAX_HW) ? MAX_HW : hw_data;

        case ($urandom_range(0, 7))
            0:       hg = 0;
            1:       hg = 31;
            2:       hg = $urandom_range((hw_eff < 31) ? hw_eff : 31, 31);
            default: hg = $urandom_range(0, (hw_eff - 1 < 4) ? hw_eff - 1 : 4);
        endcase

        if (phase_no == 0)
            scale_v = '1;
        else
        begin
            case ($urandom_range(0, 7))
                0:       scale_v = '0;
                1:       scale_v = '1;
                2:       scale_v = SCALE_RST;
                3:       scale_v = CFG_DATA_W'($urandom);
                default: scale_v = CFG_DATA_W'($urandom_range(0, 262143));
            endcase
        end

        write_reg(REG_WIN_SPAN, {17'($urandom), 7'(hw_data)});
        write_reg(REG_GUARD_SPAN, {19'($urandom), 5'(hg)});
        write_reg(REG_THRESHOLD_SCALE, scale_v);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;

        n = 2 * hw_eff + 1 + $urandom_range(4, 40);
        for (i = 0; i < n; i++)
        begin
            if (i == 0)
                f = ($urandom_range(0, 3) != 0);
            else
                f = ($urandom_range(0, 4 * hw_eff + 40) == 0);
            send_sample(rand_sample(), f);
            random_items++;
            if (random_items == QUIET_ITEMS)
                quiet <= 1'b1;
        end
        drain();
    endtask

    initial
    begin
        int p;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window half-width 2, no guard, unit scale, sample extremes
        write_reg(REG_WIN_SPAN, 24'h5A5A02);
        write_reg(REG_GUARD_SPAN, 24'h3C0020);
        write_reg(REG_THRESHOLD_SCALE, 24'h010000);
        write_reg(REG_SPARE, 24'hFFFFFF);
        cfg_write <= 1'b0;
        send_sample(sample_t'(-32768), 1'b1);
        send_sample(sample_t'(32767), 1'b0);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sample_t'(100), 1'b0);
        send_sample(sample_t'(-100), 1'b0);
        send_sample(sample_t'(32767), 1'b0);
        drain();

        // guard wider than the window
        write_reg(REG_GUARD_SPAN, 24'hFFFF1F);
        cfg_write <= 1'b0;
        send_sample(sample_t'(32767), 1'b1);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(sample_t'(32767), 1'b0);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(sample_t'(32767), 1'b0);
        send_sample(sample_t'(0), 1'b0);
        drain();

        // zero scale
        write_reg(REG_GUARD_SPAN, 24'h000001);
        write_reg(REG_THRESHOLD_SCALE, 24'h000000);
        cfg_write <= 1'b0;
        send_sample(sample_t'(0), 1'b1);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(-7), 1'b0);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(3), 1'b0);
        drain();

        for (p = 0; random_items < RANDOM_ITEMS; p++)
            run_random_phase(p);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
